### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// antecedent this cycle implies consequent next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/cmrwi_pkg.sv
`default_nettype none

package cmrwi_pkg;

    // request kinds carried on the slave tuser
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // read source codes carried on the master tuser
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_ROM  = 2'd1,
        SRC_RAM  = 2'd2,
        SRC_OPEN = 2'd3
    } t_src;

    // configuration register indexes
    localparam logic CFG_RAM_READABLE = 1'b0;
    localparam logic CFG_RAM_WRITABLE = 1'b1;

    localparam int ROM_ADDR_BITS_DEF  = 17;
    localparam int TERMINAL_COUNT_DEF = 7560;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int ROM_OUT_W   = 17;
    localparam int ROM_FULL_W  = 21;
    localparam int COUNT_W     = 13;
    localparam int RAM_AW      = 13;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [ADDR_W-1:0] RAM_WIN_LO = 16'hB800;
    localparam logic [ADDR_W-1:0] RAM_WIN_HI = 16'hD7FF;

endpackage

`default_nettype wire

### rtl/cart_mapper_ram_window_irq_core.sv
// a request accepted on the slave side passes the ram data stage, then the output register, to the master side
// throughput: one request per cycle while the result stream is not stalled and the ram is not being zeroed
// the output register and the ram data stage let one more request enter while a result waits
// reset: synchronous active-low; afterwards the work ram is zeroed, one byte per cycle,
// through every ram address with o_s_axis_tready low; configuration writes are taken meanwhile
`default_nettype none

module cart_mapper_ram_window_irq_core #(
    parameter int ROM_ADDR_BITS  = cmrwi_pkg::ROM_ADDR_BITS_DEF,
    parameter int TERMINAL_COUNT = cmrwi_pkg::TERMINAL_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // request stream
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [15:0] address, [23:16] write_data
    input  wire logic [cmrwi_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]                         i_s_axis_tuser,

    // result stream
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [16:0] rom_address, [24:17] read_data, [25] irq_line, [31:26] zero
    output logic [cmrwi_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // [1:0] read_source
    output logic [1:0]                              o_m_axis_tuser,

    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_index,
    input  wire logic                               i_cfg_wdata
);

    localparam int AW  = cmrwi_pkg::ADDR_W;
    localparam int DW  = cmrwi_pkg::DATA_W;
    localparam int RW  = cmrwi_pkg::ROM_OUT_W;
    localparam int FW  = cmrwi_pkg::ROM_FULL_W;
    localparam int CW  = cmrwi_pkg::COUNT_W;
    localparam int MAW = cmrwi_pkg::RAM_AW;
    localparam int RAM_DEPTH = 1 << MAW;

    // rom address wraps at the rom size
    localparam logic [FW-1:0] ROM_MASK = FW'((64'd1 << ROM_ADDR_BITS) - 64'd1);
    localparam logic [CW-1:0] TC       = CW'(TERMINAL_COUNT);
    localparam logic [MAW-1:0] RAM_LAST = {MAW{1'b1}};

    // configuration registers
    logic r_ram_readable;
    logic r_ram_writable;

    // mapper state
    logic [DW-1:0] r_bank_select, n_bank_select;
    logic [CW-1:0] r_tick_count,  n_tick_count;
    logic          r_count_enable, n_count_enable;
    logic          r_irq_pending,  n_irq_pending;

    // work ram and its clearing pass
    logic [DW-1:0]  r_ram [RAM_DEPTH];
    logic [DW-1:0]  r_ram_rdata;
    logic           r_clr_active;
    logic [MAW-1:0] r_clr_addr;

    // ram data stage
    logic                  r_s1_valid;
    cmrwi_pkg::t_src       r_s1_src;
    logic [RW-1:0]         r_s1_rom;
    logic                  r_s1_from_ram;
    logic [DW-1:0]         r_s1_odata;
    logic                  r_s1_irq;

    // output register
    logic                  r_out_valid;
    cmrwi_pkg::t_src       r_out_src;
    logic [RW-1:0]         r_out_rom;
    logic [DW-1:0]         r_out_data;
    logic                  r_out_irq;

    // request decode
    logic [AW-1:0]   req_addr;
    logic [DW-1:0]   req_wdata;
    cmrwi_pkg::t_cmd req_cmd;
    logic            accept;
    logic            s1_adv;
    logic            in_rom_win;
    logic            in_ram_win;
    logic [MAW-1:0]  ram_idx;
    logic [FW-1:0]   bank_rom_full;
    logic [FW-1:0]   fixed_rom_full;
    logic [FW-1:0]   rom_masked;

    // next stage-1 payload
    cmrwi_pkg::t_src n_src;
    logic [RW-1:0]   n_rom;
    logic            n_from_ram;
    logic [DW-1:0]   n_odata;

    // ram port controls
    logic            ram_we;
    logic [MAW-1:0]  ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic            ram_re;

    assign req_addr  = i_s_axis_tdata[AW-1:0];
    assign req_wdata = i_s_axis_tdata[AW+DW-1:AW];
    assign req_cmd   = cmrwi_pkg::t_cmd'(i_s_axis_tuser);

    // stage 1 moves on when the output register is free or being drained
    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_clr_active && (!r_s1_valid || s1_adv);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign in_rom_win = (req_addr[AW-1:AW-3] == 3'b011);
    assign in_ram_win = (req_addr >= cmrwi_pkg::RAM_WIN_LO) &&
                        (req_addr <= cmrwi_pkg::RAM_WIN_HI);
    assign ram_idx    = MAW'(req_addr - cmrwi_pkg::RAM_WIN_LO);

    // switchable 8 KB bank and fixed 32 KB bank 3
    assign bank_rom_full  = {r_bank_select, req_addr[12:0]};
    assign fixed_rom_full = FW'({2'b11, req_addr[14:0]});

    always_comb begin
        n_src      = cmrwi_pkg::SRC_NONE;
        n_from_ram = 1'b0;
        n_odata    = '0;
        rom_masked = '0;
        if (req_cmd == cmrwi_pkg::CMD_READ) begin
            if (in_rom_win) begin
                n_src      = cmrwi_pkg::SRC_ROM;
                rom_masked = bank_rom_full & ROM_MASK;
            end else if (in_ram_win) begin
                // ram window overrides the fixed bank
                if (r_ram_readable) begin
                    n_src      = cmrwi_pkg::SRC_RAM;
                    n_from_ram = 1'b1;
                end else begin
                    n_src   = cmrwi_pkg::SRC_OPEN;
                    n_odata = req_addr[AW-1:AW-DW];
                end
            end else if (req_addr[AW-1]) begin
                n_src      = cmrwi_pkg::SRC_ROM;
                rom_masked = fixed_rom_full & ROM_MASK;
            end
        end
        n_rom = rom_masked[RW-1:0];
    end

    // register writes and the tick counter
    always_comb begin
        n_bank_select  = r_bank_select;
        n_tick_count   = r_tick_count;
        n_count_enable = r_count_enable;
        n_irq_pending  = r_irq_pending;
        case (req_cmd)
            cmrwi_pkg::CMD_WRITE: begin
                if (req_addr[AW-1:AW-4] == 4'hF) begin
                    n_bank_select = req_wdata;
                end else if (req_addr[AW-1:AW-4] == 4'hE) begin
                    // irq acknowledge and counter restart
                    n_tick_count   = '0;
                    n_irq_pending  = 1'b0;
                    n_count_enable = req_wdata[1];
                end
            end
            cmrwi_pkg::CMD_TICK: begin
                // counter freezes at terminal count
                if (r_count_enable && (r_tick_count < TC)) begin
                    n_tick_count = r_tick_count + CW'(1);
                    if (n_tick_count == TC) begin
                        n_irq_pending = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ram port: clearing pass owns the write side until it finishes
    always_comb begin
        if (r_clr_active) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = accept && (req_cmd == cmrwi_pkg::CMD_WRITE) && in_ram_win &&
                        (req_addr[AW-1:AW-3] != 3'b111) && r_ram_writable;
            ram_waddr = ram_idx;
            ram_wdata = req_wdata;
        end
        ram_re = accept && n_from_ram;
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram[ram_waddr] <= ram_wdata;
        end
        if (ram_re) begin
            r_ram_rdata <= r_ram[ram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + MAW'(1);
            if (r_clr_addr == RAM_LAST) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_readable <= 1'b1;
            r_ram_writable <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == cmrwi_pkg::CFG_RAM_READABLE) begin
                r_ram_readable <= i_cfg_wdata;
            end else begin
                r_ram_writable <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select  <= '0;
            r_tick_count   <= '0;
            r_count_enable <= 1'b0;
            r_irq_pending  <= 1'b0;
        end else if (accept) begin
            r_bank_select  <= n_bank_select;
            r_tick_count   <= n_tick_count;
            r_count_enable <= n_count_enable;
            r_irq_pending  <= n_irq_pending;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src      <= n_src;
            r_s1_rom      <= n_rom;
            r_s1_from_ram <= n_from_ram;
            r_s1_odata    <= n_odata;
            r_s1_irq      <= n_irq_pending;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_src  <= r_s1_src;
            r_out_rom  <= r_s1_rom;
            r_out_data <= r_s1_from_ram ? r_ram_rdata : r_s1_odata;
            r_out_irq  <= r_s1_irq;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_src;
    assign o_m_axis_tdata  = {(cmrwi_pkg::OUT_TDATA_W - RW - DW - 1)'(0),
                              r_out_irq, r_out_data, r_out_rom};

`include "assert_macros.svh"

    // no request gets in while the ram is being zeroed
    `ASSERT_ALWAYS(a_clr_blocks, i_clk, i_rst_n, !(r_clr_active && o_s_axis_tready))

    // held irq only ever sits at terminal count
    `ASSERT_ALWAYS(a_irq_at_tc, i_clk, i_rst_n, !r_irq_pending || (r_tick_count == TC))

    // counter never passes terminal count
    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_tick_count <= TC)

    // a waiting result in the ram stage is not dropped while the output stalls
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && r_out_valid && !i_m_axis_tready, r_s1_valid)

endmodule

`default_nettype wire

### tb/sv/cart_mapper_ram_window_irq_core_test.sv
`default_nettype none

module cart_mapper_ram_window_irq_core_test;

    localparam int ADDR_W      = cmrwi_pkg::ADDR_W;
    localparam int DATA_W      = cmrwi_pkg::DATA_W;
    localparam int COUNT_W     = cmrwi_pkg::COUNT_W;
    localparam int RAM_AW      = cmrwi_pkg::RAM_AW;
    localparam int ROM_OUT_W   = cmrwi_pkg::ROM_OUT_W;
    localparam int ROM_FULL_W  = cmrwi_pkg::ROM_FULL_W;
    localparam int IN_TDATA_W  = cmrwi_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = cmrwi_pkg::OUT_TDATA_W;

    localparam int ROM_BITS = cmrwi_pkg::ROM_ADDR_BITS_DEF;
    localparam logic [COUNT_W-1:0] TERM_COUNT = COUNT_W'(cmrwi_pkg::TERMINAL_COUNT_DEF);
    localparam logic [ROM_FULL_W-1:0] ROM_MASK = ROM_FULL_W'((1 << ROM_BITS) - 1);

    // one bus request as it travels on the slave side
    typedef struct {
        cmrwi_pkg::t_cmd   cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_bus_request;

    // one mapper answer as it travels on the master side
    typedef struct {
        cmrwi_pkg::t_src      source;
        logic [ROM_OUT_W-1:0] rom;
        logic [DATA_W-1:0]    rdata;
        logic                 irq;
    } t_mapper_result;

    // dut inputs, all known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [1:0]            i_s_axis_tuser = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = 1'b0;
    logic                  i_cfg_wdata = 1'b0;

    // dut outputs
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [1:0]             o_m_axis_tuser;

    cart_mapper_ram_window_irq_core #(
        .ROM_ADDR_BITS  (ROM_BITS),
        .TERMINAL_COUNT (cmrwi_pkg::TERMINAL_COUNT_DEF)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [15:0] address, [23:16] write_data
        .i_s_axis_tuser  (i_s_axis_tuser),   // [1:0] command
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [16:0] rom, [24:17] data, [25] irq, [31:26] 0
        .o_m_axis_tuser  (o_m_axis_tuser),   // [1:0] read_source
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // requests waiting to go out, and answers waiting to come back
    t_bus_request   req_queue[$];
    t_mapper_result pending_results[$];

    // bookkeeping, each written by the process named beside it
    int  pushed_count = 0;   // stimulus process
    int  taken_count = 0;    // monitor
    int  results_seen = 0;   // monitor
    int  mismatches = 0;     // monitor, and the final check
    logic req_taken = 1'b0;  // monitor, read by the driver

    // traffic shaping knobs, set by the stimulus at rising edges (not hold_seen, hold_left)
    int src_idle_pct = 17;
    int snk_idle_pct = 56;
    bit src_pause = 1'b0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // mirror of the mapper state
    logic              cfg_readable;
    logic              cfg_writable;
    logic [7:0]        bank_reg;
    logic [COUNT_W-1:0] tick_cnt;
    logic              cnt_en;
    logic              irq_held;
    logic [DATA_W-1:0] ram_image [0:(1 << RAM_AW)-1];

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: decodes one accepted request against the mirrored state
    // ------------------------------------------------------------------
    function automatic bit in_ram_window(input logic [ADDR_W-1:0] addr);
        return addr >= cmrwi_pkg::RAM_WIN_LO && addr <= cmrwi_pkg::RAM_WIN_HI;
    endfunction

    task automatic decode_access(input t_bus_request rq);
        t_mapper_result          res;
        logic [ROM_FULL_W-1:0]   full;
        logic [RAM_AW-1:0]       ram_ix;
        res.source = cmrwi_pkg::SRC_NONE;
        res.rom    = '0;
        res.rdata  = '0;
        ram_ix     = RAM_AW'(rq.addr - cmrwi_pkg::RAM_WIN_LO);
        case (rq.cmd)
            cmrwi_pkg::CMD_READ: begin
                if (rq.addr >= 16'h6000 && rq.addr <= 16'h7FFF) begin
                    // switchable 8 kB bank
                    full       = {bank_reg, rq.addr[12:0]} & ROM_MASK;
                    res.source = cmrwi_pkg::SRC_ROM;
                    res.rom    = full[ROM_OUT_W-1:0];
                end else if (in_ram_window(rq.addr)) begin
                    // work ram window wins over the fixed bank
                    if (cfg_readable) begin
                        res.source = cmrwi_pkg::SRC_RAM;
                        res.rdata  = ram_image[ram_ix];
                    end else begin
                        res.source = cmrwi_pkg::SRC_OPEN;
                        res.rdata  = rq.addr[15:8];
                    end
                end else if (rq.addr[15]) begin
                    // fixed 32 kB bank 3
                    full       = {4'd0, 2'b11, rq.addr[14:0]} & ROM_MASK;
                    res.source = cmrwi_pkg::SRC_ROM;
                    res.rom    = full[ROM_OUT_W-1:0];
                end
            end
            cmrwi_pkg::CMD_WRITE: begin
                if (rq.addr >= 16'hF000) begin
                    bank_reg = rq.wdata;
                end else if (rq.addr >= 16'hE000) begin
                    // irq acknowledge, counter restart
                    tick_cnt = '0;
                    irq_held = 1'b0;
                    cnt_en   = rq.wdata[1];
                end else if (in_ram_window(rq.addr) && cfg_writable) begin
                    ram_image[ram_ix] = rq.wdata;
                end
            end
            cmrwi_pkg::CMD_TICK: begin
                // counter saturates at terminal count and holds the irq
                if (cnt_en && tick_cnt < TERM_COUNT) begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt == TERM_COUNT) irq_held = 1'b1;
                end
            end
            default: ;
        endcase
        res.irq = irq_held;
        pending_results.push_back(res);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h want %0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // monitor: samples both handshakes and the config port at rising edges
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bus_request   rq;
        t_mapper_result want;
        if (!i_rst_n) begin
            cfg_readable = 1'b1;
            cfg_writable = 1'b1;
            bank_reg     = '0;
            tick_cnt     = '0;
            cnt_en       = 1'b0;
            irq_held     = 1'b0;
            foreach (ram_image[k]) ram_image[k] = '0;
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cmrwi_pkg::CFG_RAM_READABLE: cfg_readable = i_cfg_wdata;
                    cmrwi_pkg::CFG_RAM_WRITABLE: cfg_writable = i_cfg_wdata;
                    default: ;
                endcase
            end

            // request side
            req_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                rq.cmd   = cmrwi_pkg::t_cmd'(i_s_axis_tuser);
                rq.addr  = i_s_axis_tdata[15:0];
                rq.wdata = i_s_axis_tdata[23:16];
                decode_access(rq);
                taken_count++;
            end

            // result side
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with nothing pending", o_m_axis_tdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_axis_tuser !== want.source)
                        flag_mismatch("read_source", 32'(o_m_axis_tuser),
                                      32'(want.source));
                    if (o_m_axis_tdata[16:0] !== want.rom)
                        flag_mismatch("rom_address", 32'(o_m_axis_tdata[16:0]),
                                      32'(want.rom));
                    if (o_m_axis_tdata[24:17] !== want.rdata)
                        flag_mismatch("read_data", 32'(o_m_axis_tdata[24:17]),
                                      32'(want.rdata));
                    if (o_m_axis_tdata[25] !== want.irq)
                        flag_mismatch("irq_line", 32'(o_m_axis_tdata[25]),
                                      32'(want.irq));
                    if (o_m_axis_tdata[31:26] !== '0)
                        flag_mismatch("tdata padding", 32'(o_m_axis_tdata[31:26]), '0);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: falling-edge updates of both stream sides
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_bus_request nxt;
        // a new request goes out only when the slot is free
        if (!i_s_axis_tvalid || req_taken) begin
            if (i_rst_n && !src_pause && req_queue.size() != 0 &&
                $urandom_range(99) >= src_idle_pct) begin
                nxt = req_queue.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {nxt.wdata, nxt.addr};
                i_s_axis_tuser  <= nxt.cmd;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        // receiver backpressure, forced low during a long hold
        i_m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end

    // long receiver hold, armed by bumping hold_asked
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            hold_left <= 400;
            hold_seen <= hold_asked;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(input cmrwi_pkg::t_cmd cmd, input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] wdata);
        t_bus_request rq;
        rq.cmd   = cmd;
        rq.addr  = addr;
        rq.wdata = wdata;
        req_queue.push_back(rq);
        pushed_count++;
    endtask

    // random request; a counting run is mostly ticks and never acks the counter
    function automatic t_bus_request random_request(input bit count_run);
        t_bus_request rq;
        int pick;
        pick = $urandom_range(99);
        if (count_run)
            rq.cmd = pick < 94 ? cmrwi_pkg::CMD_TICK :
                     (pick < 97 ? cmrwi_pkg::CMD_READ : cmrwi_pkg::CMD_WRITE);
        else
            rq.cmd = pick < 45 ? cmrwi_pkg::CMD_READ : pick < 80 ? cmrwi_pkg::CMD_WRITE :
                     pick < 95 ? cmrwi_pkg::CMD_TICK : cmrwi_pkg::CMD_NOP;
        pick = $urandom_range(99);
        if (pick < 15) begin
            // small hot spot so reads land on written bytes
            rq.addr = cmrwi_pkg::RAM_WIN_LO + 16'($urandom_range(15));
        end else if (pick < 25) begin
            rq.addr = 16'($urandom_range(cmrwi_pkg::RAM_WIN_LO, cmrwi_pkg::RAM_WIN_HI));
        end else if (pick < 30) begin
            case ($urandom_range(3))
                0: rq.addr = cmrwi_pkg::RAM_WIN_LO - 1'b1;
                1: rq.addr = cmrwi_pkg::RAM_WIN_LO;
                2: rq.addr = cmrwi_pkg::RAM_WIN_HI;
                default: rq.addr = cmrwi_pkg::RAM_WIN_HI + 1'b1;
            endcase
        end else if (pick < 45) begin
            rq.addr = 16'($urandom_range(16'h6000, 16'h7FFF));
        end else if (pick < 57) begin
            rq.addr = 16'($urandom_range(16'hF000, 16'hFFFF));
        end else if (pick < 65) begin
            rq.addr = 16'($urandom_range(16'hE000, 16'hEFFF));
        end else if (pick < 80) begin
            rq.addr = 16'($urandom_range(16'h8000, 16'hFFFF));
        end else begin
            rq.addr = 16'($urandom_range(16'hFFFF));
        end
        rq.wdata = 8'($urandom_range(255));
        // keep the counter running: steer acks to the bank register instead
        if (count_run && rq.cmd == cmrwi_pkg::CMD_WRITE && rq.addr[15:12] == 4'hE)
            rq.addr[12] = 1'b1;
        return rq;
    endfunction

    task automatic queue_random(input int count, input bit count_run);
        t_bus_request rq;
        repeat (count) begin
            rq = random_request(count_run);
            queue_request(rq.cmd, rq.addr, rq.wdata);
        end
    endtask

    task automatic write_cfg(input logic idx, input logic val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // wait until every queued request has produced its answer
    task automatic drain();
        do @(negedge i_clk); while (results_seen != pushed_count);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        @(posedge i_clk);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
    endtask

    initial begin
        // reset held from time zero, released on a falling edge
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both registers written once at their reset values while ram clears
        write_cfg(cmrwi_pkg::CFG_RAM_READABLE, 1'b1);
        write_cfg(cmrwi_pkg::CFG_RAM_WRITABLE, 1'b1);

        // directed: decode boundaries, bank wrap, ram window edges, counter
        @(posedge i_clk);
        queue_request(cmrwi_pkg::CMD_READ,  16'h0000, 8'h00);   // below every window
        queue_request(cmrwi_pkg::CMD_READ,  16'h5FFF, 8'hFF);
        queue_request(cmrwi_pkg::CMD_READ,  16'h6000, 8'h00);   // bank 0 start
        queue_request(cmrwi_pkg::CMD_READ,  16'hB800, 8'h00);   // ram after clearing
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hF000, 8'hFF);   // highest bank, wraps
        queue_request(cmrwi_pkg::CMD_READ,  16'h7FFF, 8'h00);
        queue_request(cmrwi_pkg::CMD_READ,  16'h8000, 8'h00);   // fixed bank start
        queue_request(cmrwi_pkg::CMD_READ,  16'hB7FF, 8'h00);   // just below ram window
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hB800, 8'hA5);
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hD7FF, 8'h5A);
        queue_request(cmrwi_pkg::CMD_READ,  16'hB800, 8'h00);
        queue_request(cmrwi_pkg::CMD_READ,  16'hD7FF, 8'h00);
        queue_request(cmrwi_pkg::CMD_READ,  16'hD800, 8'h00);   // just above ram window
        queue_request(cmrwi_pkg::CMD_READ,  16'hFFFF, 8'h00);
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hFFFF, 8'h00);   // bank back to 0
        queue_request(cmrwi_pkg::CMD_READ,  16'h6123, 8'h00);
        queue_request(cmrwi_pkg::CMD_TICK,  16'h0000, 8'h00);   // tick while disabled
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hE000, 8'h02);   // enable counter
        queue_request(cmrwi_pkg::CMD_TICK,  16'hFFFF, 8'hFF);
        queue_request(cmrwi_pkg::CMD_TICK,  16'h0000, 8'h00);
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hEFFF, 8'hFD);   // clear and disable
        queue_request(cmrwi_pkg::CMD_TICK,  16'h0000, 8'h00);
        queue_request(cmrwi_pkg::CMD_NOP,   16'hFFFF, 8'hFF);   // unused command
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hDFFF, 8'h77);   // write to nothing
        queue_request(cmrwi_pkg::CMD_WRITE, 16'h0000, 8'h33);
        drain();

        // neither readable nor writable: open bus, writes dropped
        write_cfg(cmrwi_pkg::CFG_RAM_READABLE, 1'b0);
        write_cfg(cmrwi_pkg::CFG_RAM_WRITABLE, 1'b0);
        @(posedge i_clk);
        queue_random(300, 1'b0);
        drain();

        // readable but write protected
        write_cfg(cmrwi_pkg::CFG_RAM_READABLE, 1'b1);
        @(posedge i_clk);
        queue_random(300, 1'b0);
        drain();

        // swap the idling sides, and stall the receiver long enough to back up
        set_idling(56, 17);
        write_cfg(cmrwi_pkg::CFG_RAM_READABLE, 1'b0);
        write_cfg(cmrwi_pkg::CFG_RAM_WRITABLE, 1'b1);
        @(posedge i_clk);
        queue_random(350, 1'b0);
        while (results_seen < pushed_count - 300) @(negedge i_clk);
        @(posedge i_clk);
        hold_asked++;
        drain();

        // no idling; the sender stops midway until everything has come back
        set_idling(0, 0);
        write_cfg(cmrwi_pkg::CFG_RAM_READABLE, 1'b1);
        @(posedge i_clk);
        queue_random(350, 1'b0);
        while (results_seen < pushed_count - 200) @(negedge i_clk);
        @(posedge i_clk);
        src_pause = 1'b1;
        do @(negedge i_clk); while (i_s_axis_tvalid || taken_count != results_seen);
        @(posedge i_clk);
        src_pause = 1'b0;
        drain();

        // long counting run with the counter enabled, then acknowledge
        @(posedge i_clk);
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hE000 + 16'($urandom_range(16'h0FFF)),
                      8'($urandom_range(255)) | 8'h02);
        queue_random(400, 1'b1);
        queue_request(cmrwi_pkg::CMD_READ,  16'hB900, 8'h00);
        queue_request(cmrwi_pkg::CMD_TICK,  16'h0000, 8'h00);
        queue_request(cmrwi_pkg::CMD_WRITE, 16'hE800, 8'h00);   // acknowledge, stop
        queue_request(cmrwi_pkg::CMD_TICK,  16'h0000, 8'h00);
        queue_request(cmrwi_pkg::CMD_READ,  16'hC000, 8'h00);
        drain();

        // settle and look for stray results
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch("answers never delivered", 32'(pending_results.size()), '0);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/cmrwi_pkg.sv
rtl/cart_mapper_ram_window_irq_core.sv
tb/sv/cart_mapper_ram_window_irq_core_test.sv
